>>> design/hilp_pkg.sv
// Package for the linear-probing hash insert block.
// Holds field widths, status codes and reset constants; depends on nothing.
package hilp_pkg;

    localparam int KEY_W    = 31;
    localparam int CFG_W    = 5;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;
    localparam int COUNT_W  = 32;

    // One remainder bit is produced per step of the division unit.
    localparam int DIV_STEPS = KEY_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0]    CFG_RESET = 5'd10;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

    localparam logic [STATUS_W-1:0] STATUS_HOME   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PROBED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

endpackage

>>> design/hash_insert_linear_probe_top.sv
// Top level of the linear-probing hash insert block.
// Depends on hilp_pkg for widths, status codes and reset constants.
//
// Each input beat carries one key. The home slot is the key modulo the active slot count,
// computed by a restoring divider that produces one remainder bit per cycle. The home
// slot is then checked in ST_HOME, and each further probe step in ST_PROBE visits one
// slot per cycle until a free slot is found or the probe wraps back to the home slot.
// The result is held in an output register, so a new key is accepted while the previous
// result waits to be taken. Occupancy is kept in valid bits cleared at reset; the slot
// count register is taken as 1 when written 0 and as SLOTS when written above SLOTS.
module hash_insert_linear_probe_top
    import hilp_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_slots_in_use_we,
    input  logic [CFG_W-1:0]    i_slots_in_use,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KEY_W-1:0]    i_key,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_slot_index,
    output logic [COUNT_W-1:0]  o_collision_total
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index width
    localparam int NW = $clog2(SLOTS + 1);                // slot count width

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOME,
        ST_PROBE,
        ST_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_cfg, n_cfg;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [NW-1:0]        r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [SW-1:0]        r_pos, n_pos;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [SLOTS-1:0]     r_valid, n_valid;
    logic [COUNT_W-1:0]   r_coll, n_coll;
    logic                 r_o_valid, n_o_valid;
    logic [STATUS_W-1:0]  r_o_status, n_o_status;
    logic [IDX_W-1:0]     r_o_slot, n_o_slot;
    logic [COUNT_W-1:0]   r_o_coll, n_o_coll;

    logic [NW-1:0]        act_n;
    logic [NW:0]          div_sh;
    logic [NW:0]          div_n;
    logic [SW-1:0]        home;
    logic [NW-1:0]        pos_inc;
    logic [SW-1:0]        nxt;
    logic                 out_free;

    // Clamp the configured slot count into 1..SLOTS.
    always_comb begin
        if (r_cfg == '0) begin
            act_n = NW'(1);
        end else if (32'(r_cfg) > 32'(SLOTS)) begin
            act_n = NW'(SLOTS);
        end else begin
            act_n = NW'(r_cfg);
        end
    end

    // Restoring division step: the partial remainder stays below act_n, so the shifted
    // value stays below twice act_n and one compare and subtract suffices.
    assign div_sh = {r_rem, r_key[KEY_W-1]};
    assign div_n  = {1'b0, act_n};
    assign home   = r_rem[SW-1:0];

    assign pos_inc = NW'(r_pos) + NW'(1);
    assign nxt     = (pos_inc == act_n) ? '0 : pos_inc[SW-1:0];

    assign out_free = !r_o_valid || i_ready;

    always_comb begin
        n_state    = r_state;
        n_cfg      = r_cfg;
        n_key      = r_key;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_status   = r_status;
        n_valid    = r_valid;
        n_coll     = r_coll;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_slot   = r_o_slot;
        n_o_coll   = r_o_coll;

        if (i_slots_in_use_we) begin
            n_cfg = i_slots_in_use;
        end
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_key   = i_key;
                    n_rem   = '0;
                    n_cnt   = DIV_CNT_W'(DIV_STEPS - 1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_key = {r_key[KEY_W-2:0], 1'b0};
                if (div_sh >= div_n) begin
                    n_rem = NW'(div_sh - div_n);
                end else begin
                    n_rem = NW'(div_sh);
                end
                if (r_cnt == '0) begin
                    n_state = ST_HOME;
                end else begin
                    n_cnt = r_cnt - DIV_CNT_W'(1);
                end
            end
            ST_HOME: begin
                n_pos = home;
                if (!r_valid[home]) begin
                    n_valid[home] = 1'b1;
                    n_status      = STATUS_HOME;
                    n_state       = ST_EMIT;
                end else begin
                    if (r_coll != COUNT_MAX) begin
                        n_coll = r_coll + COUNT_W'(1);
                    end
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (nxt == home) begin
                    n_pos    = home;
                    n_status = STATUS_FULL;
                    n_state  = ST_EMIT;
                end else if (!r_valid[nxt]) begin
                    n_valid[nxt] = 1'b1;
                    n_pos        = nxt;
                    n_status     = STATUS_PROBED;
                    n_state      = ST_EMIT;
                end else begin
                    n_pos = nxt;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_slot   = IDX_W'(r_pos);
                    n_o_coll   = r_coll;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= CFG_RESET;
            r_valid   <= '0;
            r_coll    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cfg     <= n_cfg;
            r_valid   <= n_valid;
            r_coll    <= n_coll;
            r_o_valid <= n_o_valid;
        end
        r_key      <= n_key;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_coll   <= n_o_coll;
    end

    assign o_ready           = (r_state == ST_IDLE);
    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_slot_index      = r_o_slot;
    assign o_collision_total = r_o_coll;

    // The collision count only ever grows.
    a_coll_monotonic: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n) |-> r_coll >= $past(r_coll))
        else $error("collision count decreased");

    // Probing only happens after the home slot was found occupied.
    a_probe_home_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> r_valid[home])
        else $error("probing while home slot is free");

    // The probe position stays inside the active slot range.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (NW'(r_pos) < act_n))
        else $error("probe position outside active slots");

    // A placed key leaves its slot marked occupied.
    a_placed_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && (r_status != STATUS_FULL) |-> r_valid[r_pos])
        else $error("placed slot not marked occupied");

endmodule

>>> tb/tb_hash_insert_linear_probe_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for hash_insert_linear_probe_top: inserts keys into the table
// and compares every result beat against an in-bench model. Depends on hilp_pkg.
module tb_hash_insert_linear_probe_top;
    import hilp_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE_GAP  = 8;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot;
        logic [COUNT_W-1:0]  total;
    } t_insert_result;

    class t_hash_insert_scoreboard;
        bit                 occupied [TABLE_SLOTS];
        logic [COUNT_W-1:0] collisions;
        logic [CFG_W-1:0]   slot_count;
        t_insert_result     expected_results[$];
        int                 errors;
        int                 checked;

        function new();
            foreach (occupied[i]) occupied[i] = 1'b0;
            collisions = '0;
            slot_count = CFG_RESET;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_slot_count(logic [CFG_W-1:0] value);
            slot_count = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Works out the outcome of one accepted key and updates the occupancy copy.
        function void note_key(logic [KEY_W-1:0] key);
            int unsigned    n;
            int unsigned    home;
            int unsigned    pos;
            bit             placed;
            t_insert_result res;
            n = slot_count;
            if (n == 0) n = 1;
            if (n > TABLE_SLOTS) n = TABLE_SLOTS;
            home = int'(key) % n;
            pos = home;
            if (!occupied[home]) begin
                occupied[home] = 1'b1;
                res.status = STATUS_HOME;
            end else begin
                if (collisions != COUNT_MAX) collisions = collisions + 1;
                placed = 1'b0;
                for (int step = 1; step < n && !placed; step++) begin
                    pos = (home + step) % n;
                    if (!occupied[pos]) begin
                        occupied[pos] = 1'b1;
                        placed = 1'b1;
                    end
                end
                if (placed) begin
                    res.status = STATUS_PROBED;
                end else begin
                    res.status = STATUS_FULL;
                    pos = home;
                end
            end
            res.slot  = pos[IDX_W-1:0];
            res.total = collisions;
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [IDX_W-1:0] slot,
                                   logic [COUNT_W-1:0] total);
            t_insert_result res;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat: status %0d slot %0d total %0d",
                         $time, status, slot, total);
                errors++;
            end else begin
                res = expected_results.pop_front();
                checked++;
                if (status !== res.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, res.status, status);
                    errors++;
                end
                if (slot !== res.slot) begin
                    $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                             $time, res.slot, slot);
                    errors++;
                end
                if (total !== res.total) begin
                    $display("%0t: collision_total mismatch: expected %0d, actual %0d",
                             $time, res.total, total);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_slots_in_use_we;
    logic [CFG_W-1:0]    i_slots_in_use;
    logic                i_valid;
    logic                o_ready;
    logic [KEY_W-1:0]    i_key;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_slot_index;
    logic [COUNT_W-1:0]  o_collision_total;

    t_hash_insert_scoreboard sb = new();

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int keys_sent;
    int slot_settings;
    int cycle_count;

    hash_insert_linear_probe_top #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_slots_in_use_we(i_slots_in_use_we),
        .i_slots_in_use   (i_slots_in_use),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_key            (i_key),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_slot_index     (o_slot_index),
        .o_collision_total(o_collision_total)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Result side: checks each accepted beat and decides ready for the next edge.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result(o_status, o_slot_index, o_collision_total);
            if (hold_request) begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [KEY_W-1:0] random_key();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 3))
            0:       return KEY_W'($urandom_range(0, 63));
            1:       return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 63));
            default: return raw[KEY_W-1:0];
        endcase
    endfunction

    task automatic send_key(input logic [KEY_W-1:0] key);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_key   <= key;
        do @(posedge i_clk); while (!o_ready);
        sb.note_key(key);
        keys_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic load_slot_count(input logic [CFG_W-1:0] value);
        drain_results();
        i_slots_in_use_we <= 1'b1;
        i_slots_in_use    <= value;
        @(posedge i_clk);
        i_slots_in_use_we <= 1'b0;
        sb.set_slot_count(value);
        slot_settings++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] slot_count, input int items,
                             input int send_pct, input int recv_pct,
                             input bit long_hold, input bit mid_pause);
        load_slot_count(slot_count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        // The sink stops taking results while keys keep coming, so the input backs up.
        if (long_hold) hold_request = 1'b1;
        for (int i = 0; i < items; i++) begin
            if (mid_pause && i == items / 2) drain_results();
            send_key(random_key());
        end
    endtask

    initial begin : stimulus
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_key             = '0;
        i_slots_in_use_we = 1'b0;
        i_slots_in_use    = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_request      = 1'b0;
        keys_sent         = 0;
        slot_settings     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset slot count is used before any write.
        send_key({KEY_W{1'b1}});
        // A count of zero behaves as one slot, so the second key finds the table full.
        load_slot_count(5'd0);
        send_key('0);
        send_key(KEY_W'(5));
        load_slot_count(5'd2);
        send_key(KEY_W'(3));
        send_key(KEY_W'(1));
        load_slot_count(5'd5);
        send_key(KEY_W'(2));
        send_key(KEY_W'(7));
        send_key(KEY_W'(12));
        send_key(KEY_W'(4));
        // Probes here wrap past the last slot; the last two keys find no free slot.
        load_slot_count(5'd9);
        send_key(KEY_W'(17));
        send_key(KEY_W'(8));
        send_key(31'h2AAA_AAAA);
        send_key(31'h5555_5555);
        send_key({KEY_W{1'b1}});

        run_phase(5'd12, 190, 0, 0, 1'b0, 1'b0);
        run_phase(5'd14, 190, 61, 0, 1'b0, 1'b1);
        // A count above the table size saturates to the full table.
        run_phase(5'd31, 190, 0, 61, 1'b0, 1'b0);
        run_phase(5'd16, 190, 32, 32, 1'b0, 1'b0);
        run_phase(5'd3, 130, 0, 0, 1'b1, 1'b0);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d keys inserted under %0d slot-count writes, %0d results compared",
                 keys_sent, slot_settings, sb.checked);
        $display("tb: %0d collisions counted, %0d mismatches", sb.collisions, sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
